// ===== rtl/core/vidx_pkg.sv =====
`timescale 1ns / 1ps
// vidx_pkg: operation and status codes and the stored entry layout
// for the volume id index map; no dependencies
package vidx_pkg;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STS_EXISTS    = 2'd2;
   localparam logic [1:0] STS_FULL      = 2'd3;

   localparam int KEY_W   = 32;
   localparam int SLOT_W  = 16;
   localparam int COUNT_W = 9;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } entry_type;

endpackage

// ===== rtl/core/vidx_ram.sv =====
`timescale 1ns / 1ps
// vidx_ram: generic single write port, single read port ram
// with registered read data; no dependencies
module vidx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/volume_id_index_map.sv =====
`timescale 1ns / 1ps
// volume_id_index_map: top level, key to slot map held in one ram
// depends on vidx_pkg and vidx_ram
//
// usage
//   req channel carries one operation: action (lookup, insert, delete),
//   volume_id as key and storage_index stored on insert
//   rsp channel returns status, found_index and entry_count for each req
//   transfer, in order, one result per request
//   entries live in one ram word each (valid, key, slot); the request is
//   answered by scanning the ram one entry per cycle through its read port
//   a lookup or delete that hits entry h ends its scan at that entry; a
//   miss or a new insert scans all entries before the result is formed
//   req_ready is high only in idle, so a new request is taken only
//   after the previous one has produced its result
//   after reset a clearing pass writes every ram entry with req_ready
//   low; the entry count starts at zero
//   a result waits in the output register while rsp_ready is low; the next
//   request is still taken and scanned, and holds before it commits
module volume_id_index_map #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_volume_id,
   input  logic [15:0] req_storage_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_found_index,
   output logic [8:0]  rsp_entry_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = $bits(vidx_pkg::entry_type);
   localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         action_ff, action_in;
   logic [31:0]        key_ff, key_in;
   logic [15:0]        slot_ff, slot_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   logic [15:0]        hit_slot_ff, hit_slot_in;
   logic               free_found_ff, free_found_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_found_ff, rsp_found_in;
   logic [8:0]         rsp_count_ff, rsp_count_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   vidx_pkg::entry_type ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [EW-1:0]      ram_rdata;
   vidx_pkg::entry_type rd_entry;

   logic               match;
   logic               load;
   logic               is_ins;
   logic               is_del;
   logic               ins_ok;
   logic               del_ok;
   logic [CW+8:0]      count_wide;

   vidx_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry = vidx_pkg::entry_type'(ram_rdata);
   assign match    = rd_entry.valid && (rd_entry.key == key_ff);
   assign load     = !rsp_valid_ff || rsp_ready;
   assign is_ins   = (action_ff == vidx_pkg::ACT_INSERT);
   assign is_del   = (action_ff == vidx_pkg::ACT_DELETE);
   assign ins_ok   = is_ins && !hit_ff && free_found_ff;
   assign del_ok   = is_del && hit_ff;
   assign ram_raddr = (state_ff == ST_SCAN) ? AW'(ptr_ff + 1'b1) : '0;

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      slot_in       = slot_ff;
      ptr_in        = ptr_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_slot_in   = hit_slot_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = '0;
      req_ready     = 1'b0;
      count_wide    = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ptr_in    = AW'(ptr_ff + 1'b1);
            if (ptr_ff == LAST) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in     = req_action;
               key_in        = req_volume_id;
               slot_in       = req_storage_index;
               ptr_in        = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!rd_entry.valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = ptr_ff;
            end
            if (match) begin
               hit_in      = 1'b1;
               hit_idx_in  = ptr_ff;
               hit_slot_in = rd_entry.slot;
               state_in    = ST_FINISH;
            end else if (ptr_ff == LAST) begin
               state_in = ST_FINISH;
            end else begin
               ptr_in = AW'(ptr_ff + 1'b1);
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_found_in = '0;
               if (is_ins) begin
                  if (hit_ff) begin
                     rsp_status_in = vidx_pkg::STS_EXISTS;
                  end else if (free_found_ff) begin
                     rsp_status_in = vidx_pkg::STS_OK;
                  end else begin
                     rsp_status_in = vidx_pkg::STS_FULL;
                  end
               end else if (hit_ff) begin
                  rsp_status_in = vidx_pkg::STS_OK;
                  if (!is_del) begin
                     rsp_found_in = hit_slot_ff;
                  end
               end else begin
                  rsp_status_in = vidx_pkg::STS_NOT_FOUND;
               end
               if (ins_ok) begin
                  ram_we          = 1'b1;
                  ram_waddr       = free_idx_ff;
                  ram_wdata.valid = 1'b1;
                  ram_wdata.key   = key_ff;
                  ram_wdata.slot  = slot_ff;
                  count_in        = CW'(count_ff + 1'b1);
               end else if (del_ok) begin
                  ram_we          = 1'b1;
                  ram_waddr       = hit_idx_ff;
                  ram_wdata.valid = 1'b0;
                  ram_wdata.key   = key_ff;
                  ram_wdata.slot  = slot_ff;
                  if (count_ff != '0) begin
                     count_in = CW'(count_ff - 1'b1);
                  end
               end
               count_wide   = {9'd0, count_in};
               rsp_count_in = count_wide[8:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      key_ff        <= key_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_slot_ff   <= hit_slot_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && load && ins_ok) |=>
         count_ff == CW'($past(count_ff) + 1'b1))
      else $error("insert did not raise entry count");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && load && del_ok) |=>
         count_ff == CW'($past(count_ff) - 1'b1))
      else $error("delete did not lower entry count");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && ptr_ff == LAST) |=> state_ff == ST_IDLE)
      else $error("clearing pass did not end");

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN && !ram_we))
      else $error("transfer accepted outside idle");
`endif

endmodule
